FILE: rtl/csl_pkg.sv
// csl_pkg: shared constants, codes and controller/datapath command types
// for the curve speed limit planner; no dependencies
package csl_pkg;

    localparam int CFG_W    = 24;
    localparam int FRIC_W   = 18;
    localparam int ACCEL_W  = 24;
    localparam int MG_W     = 22;

    localparam logic [1:0] OP_CMD   = 2'd0;
    localparam logic [1:0] OP_MEAS  = 2'd1;
    localparam logic [1:0] OP_TRACK = 2'd2;

    localparam logic CFG_FRICTION = 1'b0;
    localparam logic CFG_ACCEL    = 1'b1;

    localparam logic [FRIC_W-1:0]  FRIC_RESET  = 18'd52429;
    localparam logic [ACCEL_W-1:0] ACCEL_RESET = 24'd327680;

    // g = 9.81 in Q16.16
    localparam logic [19:0]        GRAVITY_Q16 = 20'd642908;
    localparam logic signed [31:0] FIVE_METRES = 32'sd327680;

    typedef enum logic [2:0] {
        MUL_MG, MUL_RMIN, MUL_REXIT, MUL_TT, MUL_VV, MUL_AD
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE, WB_MG, WB_T2, WB_V2, WB_AD
    } wb_sel_t;

    typedef enum logic [1:0] {
        RES_NONE, RES_SPEED, RES_T, RES_AP
    } res_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        wb_sel_t  wb_sel;
        logic     sq_start;
        logic     sq_use_arg;
        res_sel_t res_sel;
        logic     decide;
        logic     brake_set;
        logic     out_ld;
    } csl_cmd_t;

    typedef struct packed {
        logic sq_busy;
        logic sq_done;
        logic approach;
        logic is_curve;
    } csl_sts_t;

endpackage

FILE: rtl/csl_sqrt.sv
// csl_sqrt: iterative floor square root of a 64-bit value, one result bit
// per cycle; no dependencies
module csl_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] x_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] rem_shift;
    logic [34:0] trial;

    assign rem_shift = {rem_reg[32:0], x_reg[63:62]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                x_reg <= {x_reg[61:0], 2'b00};
                if (rem_shift >= trial) begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;
endmodule

FILE: rtl/csl_datapath.sv
// csl_datapath: config registers, speed state, shared multiplier, braking
// test and root unit; depends on csl_pkg and csl_sqrt
module csl_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csl_pkg::csl_cmd_t    cmd,
    output csl_pkg::csl_sts_t    sts,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic [1:0]           s_operation,
    input  logic signed [31:0]   s_speed_value,
    input  logic signed [31:0]   s_curve_distance,
    input  logic [31:0]          s_left_radius,
    input  logic [31:0]          s_right_radius,
    input  logic [31:0]          s_exit_radius,
    input  logic                 s_is_curve,
    output logic [31:0]          m_max_speed,
    output logic                 m_braking
);
    import csl_pkg::*;

    logic [FRIC_W-1:0]  fric_reg;
    logic [ACCEL_W-1:0] accel_reg;
    logic signed [31:0] cur_reg;
    logic               meas_reg;
    logic signed [31:0] d_reg;
    logic [31:0]        lr_reg, rr_reg, er_reg;
    logic               curve_reg;
    logic [MG_W-1:0]    mg_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        t_reg;
    logic [63:0]        t2_reg, v2_reg;
    logic signed [63:0] ad_reg, arg_reg;
    logic               approach_reg;
    logic [31:0]        speed_reg;
    logic               brake_reg;
    logic [31:0]        out_speed_reg;
    logic               out_brake_reg;

    logic [31:0]        rmin;
    logic [31:0]        vmag;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mul_full;
    logic signed [65:0] w, ad66, a66, lim, arg66;
    logic [64:0]        vt_sum;
    logic               far_ok, near_ok, ge5;
    logic [63:0]        sq_in;
    logic               sq_busy, sq_done;
    logic [31:0]        sq_root;

    assign rmin = (lr_reg < rr_reg) ? lr_reg : rr_reg;
    assign vmag = cur_reg[31] ? 32'(-cur_reg) : 32'(cur_reg);

    // one shared signed multiplier, result registered
    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.mul_sel)
            MUL_MG: begin
                ma = {15'd0, fric_reg};
                mb = {13'd0, GRAVITY_Q16};
            end
            MUL_RMIN: begin
                ma = {11'd0, mg_reg};
                mb = {1'b0, rmin};
            end
            MUL_REXIT: begin
                ma = {11'd0, mg_reg};
                mb = {1'b0, er_reg};
            end
            MUL_TT: begin
                ma = {1'b0, t_reg};
                mb = {1'b0, t_reg};
            end
            MUL_VV: begin
                ma = {1'b0, vmag};
                mb = {1'b0, vmag};
            end
            MUL_AD: begin
                ma = {d_reg[31], d_reg};
                mb = {9'd0, accel_reg};
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end
    assign mul_full = ma * mb;

    // braking test, evaluated exactly in 66 bits
    assign w      = $signed({2'b00, v2_reg}) - $signed({2'b00, t2_reg});
    assign ad66   = {{2{ad_reg[63]}}, ad_reg};
    assign a66    = {42'd0, accel_reg};
    assign lim    = 66'sd1 <<< 60;
    assign ge5    = d_reg >= FIVE_METRES;
    assign far_ok = (ad66 <<< 1) > (w + (a66 <<< 16));
    assign near_ok = (w > lim) ? 1'b0 :
                     (w < -lim) ? 1'b1 :
                     (((ad66 <<< 3) + ad66) > ((w <<< 2) + w));
    assign vt_sum = {1'b0, v2_reg} + {1'b0, t2_reg};
    assign arg66  = ad66 + $signed({2'b00, vt_sum[64:1]});

    assign sq_in = cmd.sq_use_arg ? ((arg_reg > 64'sd0) ? 64'(arg_reg) : 64'd0)
                                  : 64'(prod_reg);

    csl_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sq_start),
        .radicand (sq_in),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fric_reg  <= FRIC_RESET;
            accel_reg <= ACCEL_RESET;
            cur_reg   <= '0;
            meas_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRICTION: fric_reg  <= cfg_data[FRIC_W-1:0];
                    CFG_ACCEL:    accel_reg <= cfg_data[ACCEL_W-1:0];
                    default:      fric_reg  <= fric_reg;
                endcase
            end
            if (cmd.load_in) begin
                if (s_operation == OP_MEAS) begin
                    cur_reg  <= s_speed_value;
                    meas_reg <= 1'b1;
                end else if (s_operation == OP_CMD && !meas_reg) begin
                    cur_reg <= s_speed_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            d_reg     <= s_curve_distance;
            lr_reg    <= s_left_radius;
            rr_reg    <= s_right_radius;
            er_reg    <= s_exit_radius;
            curve_reg <= s_is_curve;
            brake_reg <= 1'b0;
        end
        if (cmd.mul_en) prod_reg <= mul_full[63:0];
        case (cmd.wb_sel)
            WB_MG:   mg_reg <= MG_W'((prod_reg[37:0] + 38'd32768) >> 16);
            WB_T2:   t2_reg <= 64'(prod_reg);
            WB_V2:   v2_reg <= 64'(prod_reg);
            WB_AD:   ad_reg <= prod_reg;
            default: ;
        endcase
        case (cmd.res_sel)
            RES_SPEED: speed_reg <= sq_root;
            RES_T:     t_reg     <= sq_root;
            RES_AP:    if (sq_root < speed_reg) speed_reg <= sq_root;
            default:   ;
        endcase
        if (cmd.decide) begin
            approach_reg <= ge5 ? far_ok : near_ok;
            arg_reg      <= arg66[63:0];
        end
        if (cmd.brake_set) begin
            speed_reg <= t_reg;
            brake_reg <= 1'b1;
        end
        if (cmd.out_ld) begin
            out_speed_reg <= speed_reg;
            out_brake_reg <= brake_reg;
        end
    end

    assign sts.sq_busy  = sq_busy;
    assign sts.sq_done  = sq_done;
    assign sts.approach = approach_reg;
    assign sts.is_curve = curve_reg;

    assign m_max_speed = out_speed_reg;
    assign m_braking   = out_brake_reg;
endmodule

FILE: rtl/csl_ctrl.sv
// csl_ctrl: sequencer for one track evaluation and the input/output words
// handshakes; depends on csl_pkg
module csl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    output logic              m_valid,
    input  logic              m_ready,
    input  csl_pkg::csl_sts_t sts,
    output csl_pkg::csl_cmd_t cmd
);
    import csl_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MG_MUL, ST_MG_WB, ST_RM_MUL, ST_RM_SQ, ST_RM_WAIT,
        ST_RX_MUL, ST_RX_SQ, ST_RX_WAIT, ST_TT_MUL, ST_TT_WB, ST_VV_MUL,
        ST_VV_WB, ST_AD_MUL, ST_AD_WB, ST_DECIDE, ST_CHOOSE, ST_AP_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd        = '0;
        cmd.mul_sel = MUL_MG;
        cmd.wb_sel  = WB_NONE;
        cmd.res_sel = RES_NONE;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    if (s_operation == OP_TRACK) state_next = ST_MG_MUL;
                end
            end
            ST_MG_MUL: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_MG; state_next = ST_MG_WB;
            end
            ST_MG_WB: begin
                cmd.wb_sel = WB_MG; state_next = ST_RM_MUL;
            end
            ST_RM_MUL: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_RMIN; state_next = ST_RM_SQ;
            end
            ST_RM_SQ: begin
                cmd.sq_start = 1'b1; state_next = ST_RM_WAIT;
            end
            ST_RM_WAIT: begin
                if (sts.sq_done) begin
                    cmd.res_sel = RES_SPEED;
                    state_next  = sts.is_curve ? ST_RX_MUL : ST_OUT;
                end
            end
            ST_RX_MUL: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_REXIT; state_next = ST_RX_SQ;
            end
            ST_RX_SQ: begin
                cmd.sq_start = 1'b1; state_next = ST_RX_WAIT;
            end
            ST_RX_WAIT: begin
                if (sts.sq_done) begin
                    cmd.res_sel = RES_T; state_next = ST_TT_MUL;
                end
            end
            ST_TT_MUL: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_TT; state_next = ST_TT_WB;
            end
            ST_TT_WB: begin
                cmd.wb_sel = WB_T2; state_next = ST_VV_MUL;
            end
            ST_VV_MUL: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_VV; state_next = ST_VV_WB;
            end
            ST_VV_WB: begin
                cmd.wb_sel = WB_V2; state_next = ST_AD_MUL;
            end
            ST_AD_MUL: begin
                cmd.mul_en = 1'b1; cmd.mul_sel = MUL_AD; state_next = ST_AD_WB;
            end
            ST_AD_WB: begin
                cmd.wb_sel = WB_AD; state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1; state_next = ST_CHOOSE;
            end
            ST_CHOOSE: begin
                if (sts.approach) begin
                    cmd.sq_start = 1'b1; cmd.sq_use_arg = 1'b1;
                    state_next = ST_AP_WAIT;
                end else begin
                    cmd.brake_set = 1'b1; state_next = ST_OUT;
                end
            end
            ST_AP_WAIT: begin
                if (sts.sq_done) begin
                    cmd.res_sel = RES_AP; state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_ld = 1'b1; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_ld) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end
endmodule

FILE: rtl/curve_speed_limit_planner_unit.sv
// curve_speed_limit_planner_unit: top level, joins sequencer and datapath
// depends on csl_pkg, csl_ctrl, csl_datapath, csl_sqrt
// speed words (operations 0, 1) are taken while idle and give no result
// track word: one root on a straight; on a curve the exit-radius root, the braking test
// then braking inside braking distance or an approach root; roots use the 32-step unit
// one track word in flight; input ready again the cycle after the result is loaded
module curve_speed_limit_planner_unit (
    input  logic                aclk,
    input  logic                aresetn,
    // config write port
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    // input words
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic signed [31:0]  s_speed_value,
    input  logic signed [31:0]  s_curve_distance,
    input  logic [31:0]         s_left_radius,
    input  logic [31:0]         s_right_radius,
    input  logic [31:0]         s_exit_radius,
    input  logic                s_is_curve,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_max_speed,
    output logic                m_braking
);
    import csl_pkg::*;

    // synchronous active-low reset: speed 0, commanded source, config to defaults
    csl_cmd_t cmd;
    csl_sts_t sts;

    // sequencer: walks multiplier and root steps of one track word
    csl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // datapath: state, shared multiplier, braking test, root unit
    csl_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_operation      (s_operation),
        .s_speed_value    (s_speed_value),
        .s_curve_distance (s_curve_distance),
        .s_left_radius    (s_left_radius),
        .s_right_radius   (s_right_radius),
        .s_exit_radius    (s_exit_radius),
        .s_is_curve       (s_is_curve),
        .m_max_speed      (m_max_speed),
        .m_braking        (m_braking)
    );

    // root unit is only started when idle
    a_sq_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sq_start |-> !sts.sq_busy) else $error("root start while busy");

    // no input word taken while a root is in progress
    a_ready_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.sq_busy) else $error("ready during root");

    // a finished root follows a busy root unit
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.sq_done |-> $past(sts.sq_busy)) else $error("spurious root done");

    // results are loaded only when the output register is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!m_valid || m_ready)) else $error("result overwritten");
endmodule
